// ===== src/pad_pkg.sv =====
// shared widths, reset values, register indexes and types of the power anomaly detector
package pad_pkg;

  localparam int CUR_W      = 24;
  localparam int MV_W       = 16;
  localparam int STATE_W    = 3;
  localparam int MASK_W     = 8;
  localparam int BUSY_W     = 4;
  localparam int TOTAL_W    = 4;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int MAX_ANOMALIES_DEF = 10;
  localparam int SUBSYSTEM_BITS    = 8;

  localparam logic [MASK_W-1:0] SUBSYS_MASK =
    MASK_W'((64'd1 << SUBSYSTEM_BITS) - 64'd1);

  localparam logic [CUR_W-1:0]   SLEEP_CUR_RST  = CUR_W'(10000);
  localparam logic [CUR_W-1:0]   CRIT_CUR_RST   = CUR_W'(2000000);
  localparam logic [STATE_W-1:0] SLEEP_CODE_RST = STATE_W'(5);
  localparam logic [MV_W-1:0]    DROP_MV_RST    = MV_W'(500);
  localparam logic [BUSY_W-1:0]  BUSY_LIM_RST   = BUSY_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_CUR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_CUR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_MV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_LIM   = 3'd4;

  typedef struct packed {
    logic [CUR_W-1:0]   sleep_cur;
    logic [CUR_W-1:0]   crit_cur;
    logic [STATE_W-1:0] sleep_code;
    logic [MV_W-1:0]    drop_mv;
    logic [BUSY_W-1:0]  busy_lim;
  } pad_cfg_t;

  typedef struct packed {
    logic [CUR_W-1:0]   current_ua;
    logic [MV_W-1:0]    supply_mv;
    logic [STATE_W-1:0] pwr_mode;
    logic [MASK_W-1:0]  active_mask;
  } pad_item_t;

  typedef struct packed {
    logic               sleep_overcurrent;
    logic               sleep_entry_failed;
    logic               critical_overcurrent;
    logic               voltage_drop;
    logic [TOTAL_W-1:0] anomaly_total;
    logic               item_ignored;
  } pad_result_t;

endpackage

// ===== src/pad_in_if.sv =====
// measurement channel: valid, ready and one measurement word
interface pad_in_if import pad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CUR_W-1:0]   current_ua;
  logic [MV_W-1:0]    supply_mv;
  logic [STATE_W-1:0] pwr_mode;
  logic [MASK_W-1:0]  active_mask;

  modport source (output valid, current_ua, supply_mv, pwr_mode, active_mask,
                  input ready);
  modport sink   (input valid, current_ua, supply_mv, pwr_mode, active_mask,
                  output ready);
endinterface

// ===== src/pad_out_if.sv =====
// result channel: valid, ready and one anomaly report word
interface pad_out_if import pad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               sleep_overcurrent;
  logic               sleep_entry_failed;
  logic               critical_overcurrent;
  logic               voltage_drop;
  logic [TOTAL_W-1:0] anomaly_total;
  logic               item_ignored;

  modport source (output valid, sleep_overcurrent, sleep_entry_failed,
                  critical_overcurrent, voltage_drop, anomaly_total, item_ignored,
                  input ready);
  modport sink   (input valid, sleep_overcurrent, sleep_entry_failed,
                  critical_overcurrent, voltage_drop, anomaly_total, item_ignored,
                  output ready);
endinterface

// ===== src/power_anomaly_detector_unit.sv =====
// top level of the power anomaly detector
// Each measurement word gives exactly one report word. A word accepted on in_ch is held in
// the input register, checked in one pass against the configured limits and the stored
// voltage reference, and its report is written to the output register when that register
// is empty or out_ch takes the report held there; one word per clock is sustained while
// out_ch takes reports. That rate is set by the combinational check and saturating-counter
// update between the two registers.
// The counter saturates at MAX_ANOMALIES; anomaly_total shows its low four bits. Once
// full, every further word is reported as ignored. Limits are to be written through cfg_*
// only while no word is in flight; the block itself does not enforce this.
module power_anomaly_detector_unit import pad_pkg::*; #(
  parameter int MAX_ANOMALIES = MAX_ANOMALIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pad_in_if.sink                in_ch,
  pad_out_if.source             out_ch
);

  pad_cfg_t  cfg;
  pad_item_t item;
  logic      item_valid;
  logic      take;

  pad_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pad_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  pad_core #(
    .MAX_ANOMALIES (MAX_ANOMALIES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

// ===== src/pad_cfg_regs.sv =====
// configuration register file with write decode
module pad_cfg_regs import pad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output pad_cfg_t              cfg
);

  pad_cfg_t cfg_r;
  pad_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_SLEEP_CUR:  cfg_nxt.sleep_cur  = cfg_wdata[CUR_W-1:0];
        REG_CRIT_CUR:   cfg_nxt.crit_cur   = cfg_wdata[CUR_W-1:0];
        REG_SLEEP_CODE: cfg_nxt.sleep_code = cfg_wdata[STATE_W-1:0];
        REG_DROP_MV:    cfg_nxt.drop_mv    = cfg_wdata[MV_W-1:0];
        REG_BUSY_LIM:   cfg_nxt.busy_lim   = cfg_wdata[BUSY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_cur  <= SLEEP_CUR_RST;
      cfg_r.crit_cur   <= CRIT_CUR_RST;
      cfg_r.sleep_code <= SLEEP_CODE_RST;
      cfg_r.drop_mv    <= DROP_MV_RST;
      cfg_r.busy_lim   <= BUSY_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/pad_in_stage.sv =====
// input register stage for measurement words
module pad_in_stage import pad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pad_in_if.sink    in_ch,
  input  logic      take,
  output logic      item_valid,
  output pad_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  pad_item_t item_r;
  logic      load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.current_ua  <= in_ch.current_ua;
      item_r.supply_mv   <= in_ch.supply_mv;
      item_r.pwr_mode    <= in_ch.pwr_mode;
      item_r.active_mask <= in_ch.active_mask;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/pad_core.sv =====
// anomaly checks, saturating counter, voltage reference and result register
module pad_core import pad_pkg::*; #(
  parameter int MAX_ANOMALIES = MAX_ANOMALIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pad_cfg_t  cfg,
  input  logic      item_valid,
  input  pad_item_t item,
  output logic      take,
  pad_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_ANOMALIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ANOMALIES);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [MV_W-1:0]  prev_mv_r;
  logic             seen_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  pad_result_t      res_r;
  pad_result_t      res_nxt;

  logic [MASK_W-1:0] masked;
  logic [BUSY_W-1:0] ones;
  logic [MV_W-1:0]   floor_mv;
  logic              asleep;
  logic              ignored;
  logic              fire0, fire1, fire2, fire3;
  logic              f0, f1, f2, f3;
  logic [CNT_W-1:0]  c1, c2, c3;

  assign take = item_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    masked = item.active_mask & SUBSYS_MASK;
    ones   = '0;
    for (int i = 0; i < MASK_W; i++) begin
      ones = ones + BUSY_W'(masked[i]);
    end
  end

  assign asleep   = (item.pwr_mode == cfg.sleep_code);
  assign floor_mv = (prev_mv_r > cfg.drop_mv) ? (prev_mv_r - cfg.drop_mv) : '0;
  assign ignored  = (cnt_r >= CNT_MAX);

  assign fire0 = asleep && (item.current_ua > cfg.sleep_cur);
  assign fire1 = asleep && (ones > cfg.busy_lim);
  assign fire2 = (item.current_ua > cfg.crit_cur);
  assign fire3 = seen_r && (item.supply_mv < floor_mv);

  // each condition is counted only while the counter has room
  assign f0      = fire0 && (cnt_r < CNT_MAX);
  assign c1      = cnt_r + CNT_W'(f0);
  assign f1      = fire1 && (c1 < CNT_MAX);
  assign c2      = c1 + CNT_W'(f1);
  assign f2      = fire2 && (c2 < CNT_MAX);
  assign c3      = c2 + CNT_W'(f2);
  assign f3      = fire3 && (c3 < CNT_MAX);
  assign cnt_nxt = c3 + CNT_W'(f3);

  always_comb begin
    res_nxt.sleep_overcurrent    = f0;
    res_nxt.sleep_entry_failed   = f1;
    res_nxt.critical_overcurrent = f2;
    res_nxt.voltage_drop         = f3;
    res_nxt.anomaly_total        = TOTAL_W'(cnt_nxt);
    res_nxt.item_ignored         = ignored;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        cnt_r <= cnt_nxt;
        if (!ignored) begin
          seen_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
      if (!ignored) begin
        prev_mv_r <= item.supply_mv;
      end
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.sleep_overcurrent    = res_r.sleep_overcurrent;
  assign out_ch.sleep_entry_failed   = res_r.sleep_entry_failed;
  assign out_ch.critical_overcurrent = res_r.critical_overcurrent;
  assign out_ch.voltage_drop         = res_r.voltage_drop;
  assign out_ch.anomaly_total        = res_r.anomaly_total;
  assign out_ch.item_ignored         = res_r.item_ignored;

endmodule

// ===== src/pad_checker.sv =====
// port-level checks of the power anomaly detector and their binding
module pad_checker import pad_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               sleep_overcurrent,
  input logic               sleep_entry_failed,
  input logic               critical_overcurrent,
  input logic               voltage_drop,
  input logic [TOTAL_W-1:0] anomaly_total,
  input logic               item_ignored
);

  logic [TOTAL_W-1:0] last_total_r;
  logic [3:0]         flags;
  logic               out_acc;

  assign flags   = {sleep_overcurrent, sleep_entry_failed, critical_overcurrent, voltage_drop};
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
    end else if (out_acc) begin
      last_total_r <= anomaly_total;
    end
  end

  // total grows by exactly the number of counted anomalies
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> anomaly_total == TOTAL_W'(last_total_r + TOTAL_W'($countones(flags))))
    else $error("anomaly total does not follow counted flags");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_ignored |-> flags == 4'b0000)
    else $error("ignored word reports anomalies");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(flags) && $stable(anomaly_total)
      && $stable(item_ignored))
    else $error("stalled report changed");

endmodule

bind power_anomaly_detector_unit pad_checker u_pad_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .sleep_overcurrent    (out_ch.sleep_overcurrent),
  .sleep_entry_failed   (out_ch.sleep_entry_failed),
  .critical_overcurrent (out_ch.critical_overcurrent),
  .voltage_drop         (out_ch.voltage_drop),
  .anomaly_total        (out_ch.anomaly_total),
  .item_ignored         (out_ch.item_ignored)
);

// ===== sim/power_anomaly_detector_unit_test.sv =====
// self-checking testbench of the power anomaly detector: random bursts, stalls and limit phases
module power_anomaly_detector_unit_test;
  import pad_pkg::*;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pad_in_if  in_ch ();
  pad_out_if out_ch ();

  power_anomaly_detector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pad_item_t   pending_words[$];
  pad_result_t expected_reports[$];
  pad_item_t   offered;
  pad_result_t want_rep;

  pad_cfg_t        limits;
  logic [MV_W-1:0] prev_mv;
  logic            mv_seen;
  int              anomaly_cnt;

  int       pushed_cnt;
  int       accepted_cnt;
  int       reports_seen;
  int       mismatch_cnt;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  bit       held_once;
  int       rx_cycle;
  rx_mode_e rx_mode;
  logic [MV_W-1:0] last_mv;

  always #6 clk = ~clk;

  function automatic logic count_if_room(logic fires);
    if (fires && anomaly_cnt < MAX_ANOMALIES_DEF) begin
      anomaly_cnt++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic pad_result_t assess_measurement(pad_item_t w);
    pad_result_t     r;
    logic            asleep;
    logic [MV_W-1:0] floor_mv;
    r = '0;
    if (anomaly_cnt >= MAX_ANOMALIES_DEF) begin
      r.item_ignored = 1'b1;
    end else begin
      asleep = (w.pwr_mode == limits.sleep_code);
      r.sleep_overcurrent    = count_if_room(asleep && w.current_ua > limits.sleep_cur);
      r.sleep_entry_failed   = count_if_room(asleep &&
                                 $countones(w.active_mask & SUBSYS_MASK) > limits.busy_lim);
      r.critical_overcurrent = count_if_room(w.current_ua > limits.crit_cur);
      if (mv_seen) begin
        floor_mv = (prev_mv > limits.drop_mv) ? prev_mv - limits.drop_mv : '0;
        r.voltage_drop = count_if_room(w.supply_mv < floor_mv);
      end
      prev_mv = w.supply_mv;
      mv_seen = 1'b1;
    end
    r.anomaly_total = anomaly_cnt[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] mask_at_most(int k);
    logic [MASK_W-1:0] m;
    m = MASK_W'($urandom);
    while ($countones(m) > k) m[$urandom_range(0, MASK_W-1)] = 1'b0;
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  task automatic push_word(logic [CUR_W-1:0] cur, logic [MV_W-1:0] mv,
                           logic [STATE_W-1:0] st, logic [MASK_W-1:0] mask);
    pad_item_t w;
    w.current_ua  = cur;
    w.supply_mv   = mv;
    w.pwr_mode    = st;
    w.active_mask = mask;
    pending_words.push_back(w);
    pushed_cnt++;
    last_mv = mv;
  endtask

  task automatic wait_drained(int settle);
    while (accepted_cnt != pushed_cnt || expected_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SLEEP_CUR:  limits.sleep_cur  = data[CUR_W-1:0];
      REG_CRIT_CUR:   limits.crit_cur   = data[CUR_W-1:0];
      REG_SLEEP_CODE: limits.sleep_code = data[STATE_W-1:0];
      REG_DROP_MV:    limits.drop_mv    = data[MV_W-1:0];
      REG_BUSY_LIM:   limits.busy_lim   = data[BUSY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(int sleep_cur, int crit_cur, int code, int drop_mv, int busy);
    wait_drained(4);
    write_limit(REG_SLEEP_CUR, CFG_DATA_W'(sleep_cur));
    write_limit(REG_CRIT_CUR, CFG_DATA_W'(crit_cur));
    write_limit(REG_SLEEP_CODE, CFG_DATA_W'(code));
    write_limit(REG_DROP_MV, CFG_DATA_W'(drop_mv));
    write_limit(REG_BUSY_LIM, CFG_DATA_W'(busy));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_reports.push_back(assess_measurement(offered));
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          offered = pending_words.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.current_ua  <= offered.current_ua;
          in_ch.supply_mv   <= offered.supply_mv;
          in_ch.pwr_mode    <= offered.pwr_mode;
          in_ch.active_mask <= offered.active_mask;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each report word and stalls on its own pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          report_mismatch("report word with nothing expected", 1, 0);
        end else begin
          want_rep = expected_reports.pop_front();
          if (out_ch.sleep_overcurrent !== want_rep.sleep_overcurrent)
            report_mismatch("sleep_overcurrent", out_ch.sleep_overcurrent,
                            want_rep.sleep_overcurrent);
          if (out_ch.sleep_entry_failed !== want_rep.sleep_entry_failed)
            report_mismatch("sleep_entry_failed", out_ch.sleep_entry_failed,
                            want_rep.sleep_entry_failed);
          if (out_ch.critical_overcurrent !== want_rep.critical_overcurrent)
            report_mismatch("critical_overcurrent", out_ch.critical_overcurrent,
                            want_rep.critical_overcurrent);
          if (out_ch.voltage_drop !== want_rep.voltage_drop)
            report_mismatch("voltage_drop", out_ch.voltage_drop, want_rep.voltage_drop);
          if (out_ch.anomaly_total !== want_rep.anomaly_total)
            report_mismatch("anomaly_total", out_ch.anomaly_total, want_rep.anomaly_total);
          if (out_ch.item_ignored !== want_rep.item_ignored)
            report_mismatch("item_ignored", out_ch.item_ignored, want_rep.item_ignored);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= (hold_left == 0);
      end else if (!held_once && reports_seen >= 60) begin
        // long hold-off so the block backs up into the input
        held_once = 1'b1;
        hold_left = 150;
        out_ch.ready <= 1'b0;
      end else begin
        rx_cycle++;
        if (rx_cycle % 160 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
        case (rx_mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= ((rx_cycle % 7) >= 3);
        endcase
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int                 i;
    int                 kind;
    int                 budget;
    int                 lo_mv;
    int                 hi_mv;
    logic [CUR_W-1:0]   cur;
    logic [MV_W-1:0]    mv;
    logic [STATE_W-1:0] st;
    logic [MASK_W-1:0]  m;

    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid       = 1'b0;
    in_ch.current_ua  = '0;
    in_ch.supply_mv   = '0;
    in_ch.pwr_mode    = '0;
    in_ch.active_mask = '0;
    out_ch.ready = 1'b0;
    limits = '{SLEEP_CUR_RST, CRIT_CUR_RST, SLEEP_CODE_RST, DROP_MV_RST, BUSY_LIM_RST};
    prev_mv      = '0;
    mv_seen      = 1'b0;
    anomaly_cnt  = 0;
    pushed_cnt   = 0;
    accepted_cnt = 0;
    reports_seen = 0;
    mismatch_cnt = 0;
    burst_left   = 0;
    gap_left     = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    rx_cycle     = 0;
    rx_mode      = RX_OPEN;
    last_mv      = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset limits
    push_word(24'd0, 16'd300, 3'd0, 8'h00);          // first word loads the reference
    push_word(24'd2000000, 16'd0, 3'd7, 8'hFF);      // drop limit above the reference
    push_word(24'd10000, 16'hFFFF, 3'd5, 8'h03);     // sleep at both limits
    push_word(24'd0, 16'd65035, 3'd5, 8'h00);        // fall equal to the drop limit
    push_word(24'd10001, 16'd65035, 3'd5, 8'h07);    // sleep overcurrent and busy sleep
    push_word(24'hFFFFFF, 16'd65035, 3'd1, 8'h00);   // critical overcurrent
    push_word(24'd0, 16'd64534, 3'd3, 8'hAA);        // voltage drop
    push_word(24'h0AAAAA, 16'd64534, 3'd6, 8'h55);
    push_word(24'd1999999, 16'd64100, 3'd4, 8'hFF);
    push_word(24'd0, 16'd64000, 3'd5, 8'hC0);
    push_word(24'h0F0F0F, 16'd63600, 3'd2, 8'h0F);
    push_word(24'd9999, 16'd63200, 3'd5, 8'h81);

    // widest limits: nothing can fire, so every field bit is free
    set_limits(24'hFFFFFF, 24'hFFFFFF, 7, 16'hFFFF, 8);
    for (i = 0; i < 250; i++)
      push_word(CUR_W'($urandom), MV_W'($urandom), STATE_W'($urandom), MASK_W'($urandom));

    // mid limits: words shaped to stay quiet, with a few single anomalies
    set_limits($urandom_range(1000, 100000), $urandom_range(200000, 24'hFFFFFE),
               $urandom_range(0, 7), $urandom_range(1, 2000), $urandom_range(0, 7));
    budget = 3;
    for (i = 0; i < 350; i++) begin
      lo_mv = (last_mv > limits.drop_mv) ? last_mv - limits.drop_mv : 0;
      if (budget > 0 && $urandom_range(0, 99) == 0) begin
        budget--;
        kind = $urandom_range(0, 3);
        if (kind == 3 && last_mv <= limits.drop_mv) kind = 2;
        st  = limits.sleep_code;
        cur = CUR_W'($urandom_range(0, limits.sleep_cur));
        m   = mask_at_most(limits.busy_lim);
        mv  = last_mv;
        case (kind)
          0: cur = limits.sleep_cur + 1'b1;
          1: begin
            m = '0;
            while ($countones(m) < limits.busy_lim + 1) m[$urandom_range(0, MASK_W-1)] = 1'b1;
          end
          2: begin
            st  = limits.sleep_code + 3'd1;
            cur = CUR_W'($urandom_range(limits.crit_cur + 1, 24'hFFFFFF));
          end
          default: mv = last_mv - limits.drop_mv - 1'b1;
        endcase
      end else begin
        st = STATE_W'($urandom);
        if (st == limits.sleep_code) begin
          cur = ($urandom_range(0, 7) == 0) ? limits.sleep_cur
                                            : CUR_W'($urandom_range(0, limits.sleep_cur));
          m   = mask_at_most(limits.busy_lim);
        end else begin
          cur = ($urandom_range(0, 7) == 0) ? limits.crit_cur
                                            : CUR_W'($urandom_range(0, limits.crit_cur));
          m   = MASK_W'($urandom);
        end
        hi_mv = (last_mv + limits.drop_mv > 65535) ? 65535 : last_mv + limits.drop_mv;
        if ($urandom_range(0, 19) == 0) hi_mv = 65535;
        mv = ($urandom_range(0, 3) == 0) ? MV_W'(lo_mv) : MV_W'($urandom_range(lo_mv, hi_mv));
      end
      push_word(cur, mv, st, m);
    end

    // zero limits: everything fires, the counter fills mid word, then words are skipped
    set_limits(0, 0, 0, 0, 0);
    for (i = 0; i < 3; i++)
      push_word(24'd1, (last_mv > 0) ? last_mv - 1'b1 : '0, 3'd0, 8'h01);
    for (i = 0; i < 40; i++)
      push_word(CUR_W'($urandom), MV_W'($urandom), STATE_W'($urandom), MASK_W'($urandom));

    wait_drained(8);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== power_anomaly_detector_unit.f =====
src/pad_pkg.sv
src/pad_in_if.sv
src/pad_out_if.sv
src/pad_cfg_regs.sv
src/pad_in_stage.sv
src/pad_core.sv
src/power_anomaly_detector_unit.sv
src/pad_checker.sv
sim/power_anomaly_detector_unit_test.sv
